>>> src/ring_producer_reserve_commit_defines.svh
// ---------------------------------------------------------------------------
// Ring producer reserve/commit - assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef RING_PRODUCER_RESERVE_COMMIT_DEFINES_SVH
`define RING_PRODUCER_RESERVE_COMMIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define RPRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rprc check failed");
// Next-cycle implication.
`define RPRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rprc check failed");
`else
`define RPRC_ASSERT_SAME(label, ante, cons)
`define RPRC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> src/rprc_pkg.sv
// ---------------------------------------------------------------------------
// rprc_pkg
// Types and constants shared by the ring producer reserve/commit block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rprc_pkg;

  localparam int MAX_RING_BITS = 16;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RING_SIZE_LOG2    = 1'd0,
    REG_MAX_MESSAGE_BYTES = 1'd1
  } reg_index_t;

  localparam logic [4:0]  RESET_RING_SIZE_LOG2    = 5'd10;
  localparam logic [16:0] RESET_MAX_MESSAGE_BYTES = 17'd4096;

  typedef enum logic [1:0] {
    ACT_RESERVE  = 2'd0,
    ACT_COMMIT   = 2'd1,
    ACT_ROLLBACK = 2'd2,
    ACT_PUSH     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SIZE   = 3'd1,
    ST_CLOSED = 3'd2,
    ST_FULL   = 3'd3,
    ST_BUSY   = 3'd4,
    ST_NORES  = 3'd5
  } status_t;

  typedef struct packed {
    action_t     action;
    logic [19:0] message_length;
    logic [15:0] consumer_read_index;
    logic        reader_attached;
  } rprc_in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] slot_number;
    logic        prefix_write;
    logic [16:0] prefix_value;
    logic [15:0] published_write_index;
    logic [15:0] free_slots;
    logic [63:0] messages_total;
    logic [63:0] bytes_total;
    logic [63:0] failed_total;
  } rprc_out_t;

  typedef struct packed {
    logic [4:0]  ring_size_log2;
    logic [16:0] max_message_bytes;
  } rprc_cfg_t;

endpackage

`default_nettype wire

>>> src/rprc_core.sv
// ---------------------------------------------------------------------------
// rprc_core
// Producer state and the per-transaction decision logic (one pass).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rprc_core
  import rprc_pkg::*;
#(
  parameter int INDEX_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire rprc_cfg_t cfg,
  input  wire logic      fire,
  input  wire rprc_in_t  req,
  output rprc_out_t      result
);

  localparam int CAP_INT = (INDEX_BITS < MAX_RING_BITS) ? INDEX_BITS : MAX_RING_BITS;
  localparam logic [4:0] CAP_BITS = 5'(CAP_INT);

  logic [INDEX_BITS-1:0] write_position, write_position_next;
  logic                  holding_reservation, holding_reservation_next;
  logic [15:0]           held_slot, held_slot_next;
  logic [63:0]           sent_messages, sent_messages_next;
  logic [63:0]           sent_bytes, sent_bytes_next;
  logic [63:0]           push_failures, push_failures_next;

  logic [4:0]  eff_bits;
  logic [15:0] mask;
  logic [15:0] wp16;
  logic [15:0] wp16_next;
  logic [15:0] read_m;
  logic [15:0] used;
  logic        len_ok;
  logic        full;
  logic        publish;
  logic        fail;
  status_t     status;
  logic [15:0] slot;

  // clamp L into [1, min(16, INDEX_BITS)]
  always_comb begin
    if (cfg.ring_size_log2 == 5'd0) begin
      eff_bits = 5'd1;
    end else if (cfg.ring_size_log2 > CAP_BITS) begin
      eff_bits = CAP_BITS;
    end else begin
      eff_bits = cfg.ring_size_log2;
    end
  end

  assign mask   = ~(16'hFFFF << eff_bits);
  assign wp16   = 16'(32'(write_position));
  assign read_m = req.consumer_read_index & mask;
  assign len_ok = (req.message_length != 20'd0) &&
                  (req.message_length <= {3'b000, cfg.max_message_bytes});
  assign full   = (((wp16 + 16'd1) & mask) == read_m);

  always_comb begin
    status                   = ST_OK;
    slot                     = 16'd0;
    publish                  = 1'b0;
    fail                     = 1'b0;
    holding_reservation_next = holding_reservation;
    held_slot_next           = held_slot;
    case (req.action)
      ACT_RESERVE: begin
        if (!len_ok) begin
          status = ST_SIZE;
        end else if (holding_reservation) begin
          status = ST_BUSY;
        end else if (!req.reader_attached) begin
          status = ST_CLOSED;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          slot                     = wp16 & mask;
          holding_reservation_next = 1'b1;
          held_slot_next           = wp16 & mask;
        end
      end
      ACT_COMMIT: begin
        if (!len_ok) begin
          status = ST_SIZE;
        end else if (!holding_reservation) begin
          status = ST_NORES;
        end else begin
          slot                     = held_slot;
          publish                  = 1'b1;
          holding_reservation_next = 1'b0;
          held_slot_next           = 16'd0;
        end
      end
      ACT_ROLLBACK: begin
        holding_reservation_next = 1'b0;
        held_slot_next           = 16'd0;
      end
      default: begin // push
        if (!len_ok) begin
          status = ST_SIZE;
        end else if (!req.reader_attached) begin
          status = ST_CLOSED;
          fail   = 1'b1;
        end else if (holding_reservation || full) begin
          status = ST_FULL;
          fail   = 1'b1;
        end else begin
          slot    = wp16 & mask;
          publish = 1'b1;
        end
      end
    endcase
  end

  assign write_position_next = publish ? write_position + INDEX_BITS'(1) : write_position;
  assign sent_messages_next  = publish ? sent_messages + 64'd1 : sent_messages;
  assign sent_bytes_next     = publish ? sent_bytes + 64'(req.message_length) : sent_bytes;
  assign push_failures_next  = fail ? push_failures + 64'd1 : push_failures;

  assign wp16_next = 16'(32'(write_position_next));
  assign used      = (wp16_next - req.consumer_read_index) & mask;

  always_comb begin
    result.status                = status;
    result.slot_number           = slot;
    result.prefix_write          = publish;
    result.prefix_value          = publish ? req.message_length[16:0] : 17'd0;
    result.published_write_index = wp16_next;
    result.free_slots            = mask - used;
    result.messages_total        = sent_messages_next;
    result.bytes_total           = sent_bytes_next;
    result.failed_total          = push_failures_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position      <= '0;
      holding_reservation <= 1'b0;
      held_slot           <= 16'd0;
      sent_messages       <= 64'd0;
      sent_bytes          <= 64'd0;
      push_failures       <= 64'd0;
    end else if (fire) begin
      write_position      <= write_position_next;
      holding_reservation <= holding_reservation_next;
      held_slot           <= held_slot_next;
      sent_messages       <= sent_messages_next;
      sent_bytes          <= sent_bytes_next;
      push_failures       <= push_failures_next;
    end
  end

endmodule

`default_nettype wire

>>> src/ring_producer_reserve_commit.sv
// ---------------------------------------------------------------------------
// ring_producer_reserve_commit
// Producer side of an SPSC ring of message slots: reserve, commit,
// rollback and push, with sent/byte/failure counters.
// ---------------------------------------------------------------------------
//  channel   signals                          direction  transaction
//  in        in_valid/in_ready/in_data        input      one operation
//  out       out_valid/out_ready/out_data     output     one result per operation
//  config    cfg_we/cfg_index/cfg_data        input      register write, no wait
//
//  Path from input transaction to result valid: input register, then
//  one decision pass into the result register. One transaction per cycle
//  when results are taken, set by the single state update per operation in rprc_core.
//  rst (synchronous) clears state, counters and both stage valids and loads
//  register defaults (L = 10, max length 4096); in_ready is low during rst.
//  A stalled result holds the result register; the input register stays
//  full behind it and in_ready drops until the result is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ring_producer_reserve_commit_defines.svh"

module ring_producer_reserve_commit
  import rprc_pkg::*;
#(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire rprc_in_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output rprc_out_t                   out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  rprc_cfg_t cfg;
  rprc_in_t  s1_data;
  logic      s1_valid;
  logic      s1_fire;
  rprc_out_t result;

  // configuration registers, to be written only while idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_size_log2    <= RESET_RING_SIZE_LOG2;
      cfg.max_message_bytes <= RESET_MAX_MESSAGE_BYTES;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_RING_SIZE_LOG2:    cfg.ring_size_log2    <= cfg_data[4:0];
        REG_MAX_MESSAGE_BYTES: cfg.max_message_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1 moves into the result register when that register is free
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !rst && (!s1_valid || s1_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  rprc_core #(
    .INDEX_BITS(INDEX_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (s1_fire),
    .req    (s1_data),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

  // a decided operation always reaches the result register
  `RPRC_ASSERT_NEXT(a_fire_loads_out, s1_fire, out_valid)
  // a prefix is written only on success, and never with zero length
  `RPRC_ASSERT_SAME(a_prefix_ok, out_valid && out_data.prefix_write,
                    out_data.status == ST_OK && out_data.prefix_value != 17'd0)
  // a rejected length names no slot and writes no prefix
  `RPRC_ASSERT_SAME(a_size_no_slot, out_valid && out_data.status == ST_SIZE,
                    out_data.slot_number == 16'd0 && !out_data.prefix_write)

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench - ring_producer_reserve_commit
// Drives reserve/commit/rollback/push transactions into the ring producer,
// predicts each result from a local copy of the ring state and checks every
// result transaction field by field, with random idling on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rprc_pkg::*;

  // Ring size / max length pairs walked by the config sweep. Includes the
  // clamped sizes (0 and above 16) and a zero max length that rejects all.
  localparam int unsigned SWEEP_RING[8] = '{1, 0, 16, 31, 2, 5, 17, 10};
  localparam int unsigned SWEEP_MAX[8]  = '{1, 65536, 131071, 0, 100, 20, 4096, 4096};

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  rprc_in_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  rprc_out_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  ring_producer_reserve_commit #(
    .INDEX_BITS(16)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Local copy of the producer: register settings and ring state.
  logic [4:0]  ring_log2_cfg = RESET_RING_SIZE_LOG2;
  logic [16:0] max_len_cfg   = RESET_MAX_MESSAGE_BYTES;
  logic [15:0] wr_pos        = '0;
  bit          holding       = 1'b0;
  logic [15:0] held_slot     = '0;
  logic [63:0] msg_count     = '0;
  logic [63:0] byte_count    = '0;
  logic [63:0] fail_count    = '0;

  // Results predicted at input acceptance, oldest first.
  rprc_out_t   awaited_reports[$];
  int          mismatches = 0;

  // Traffic knobs shared between the test tasks and the result monitor.
  int          hold_req  = 0;    // one-shot long stall for the receiver
  bit          tx_steady = 1'b0; // no gaps between input transactions
  bit          rx_steady = 1'b0; // no stalls before result transactions
  logic [15:0] consumer_rd = '0; // where a well-behaved consumer has read to

  // Slot count exponent after clamping: 0 acts as 1, above 16 acts as 16.
  function automatic int unsigned live_ring_bits();
    int unsigned l;
    l = 32'(ring_log2_cfg);
    if (l < 1) l = 1;
    if (l > MAX_RING_BITS) l = MAX_RING_BITS;
    return l;
  endfunction

  // Applies one operation to the local ring state and returns its report.
  function automatic rprc_out_t apply_ring_op(input rprc_in_t op);
    rprc_out_t   r;
    int unsigned span;
    logic [15:0] mask;
    logic [15:0] used;
    bit          len_ok;
    bit          room;
    r      = '0;
    span   = 32'd1 << live_ring_bits();
    mask   = 16'(span - 1);
    len_ok = (op.message_length != 0) && (op.message_length <= max_len_cfg);
    // Ring is full when one more write would land on the reader.
    room   = ((wr_pos + 16'd1) & mask) != (op.consumer_read_index & mask);
    r.status = ST_OK;
    case (op.action)
      ACT_RESERVE: begin
        if (!len_ok) r.status = ST_SIZE;
        else if (holding) r.status = ST_BUSY;
        else if (!op.reader_attached) r.status = ST_CLOSED;
        else if (!room) r.status = ST_FULL;
        else begin
          holding       = 1'b1;
          held_slot     = wr_pos & mask;
          r.slot_number = wr_pos & mask;
        end
      end
      ACT_COMMIT: begin
        // No liveness or fullness check: the held slot is published.
        if (!len_ok) r.status = ST_SIZE;
        else if (!holding) r.status = ST_NORES;
        else begin
          r.slot_number  = held_slot;
          r.prefix_write = 1'b1;
          r.prefix_value = op.message_length[16:0];
          wr_pos         = wr_pos + 16'd1;
          msg_count      = msg_count + 64'd1;
          byte_count     = byte_count + 64'(op.message_length);
          holding        = 1'b0;
          held_slot      = '0;
        end
      end
      ACT_ROLLBACK: begin
        holding   = 1'b0;
        held_slot = '0;
      end
      ACT_PUSH: begin
        // Size errors are not failures; a held reservation reads as full.
        if (!len_ok) r.status = ST_SIZE;
        else if (!op.reader_attached) begin
          r.status   = ST_CLOSED;
          fail_count = fail_count + 64'd1;
        end else if (holding || !room) begin
          r.status   = ST_FULL;
          fail_count = fail_count + 64'd1;
        end else begin
          r.slot_number  = wr_pos & mask;
          r.prefix_write = 1'b1;
          r.prefix_value = op.message_length[16:0];
          wr_pos         = wr_pos + 16'd1;
          msg_count      = msg_count + 64'd1;
          byte_count     = byte_count + 64'(op.message_length);
        end
      end
    endcase
    used = (wr_pos - op.consumer_read_index) & mask;
    r.published_write_index = wr_pos;
    r.free_slots            = 16'(span - 32'(used) - 1);
    r.messages_total        = msg_count;
    r.bytes_total           = byte_count;
    r.failed_total          = fail_count;
    return r;
  endfunction

  function automatic rprc_in_t mk(input action_t a, input logic [19:0] len,
                                  input logic [15:0] rd, input logic alive);
    rprc_in_t op;
    op.action              = a;
    op.message_length      = len;
    op.consumer_read_index = rd;
    op.reader_attached     = alive;
    return op;
  endfunction

  // Mostly legal lengths, with zero, just-too-long and wild values mixed in.
  function automatic logic [19:0] pick_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 20'(max_len_cfg) + 20'd1;
      2: return 20'($urandom);
      3: return 20'(max_len_cfg);
      4: return 20'd1;
      default: begin
        if (max_len_cfg == 0) return 20'($urandom_range(0, 2));
        return 20'($urandom_range(1, max_len_cfg));
      end
    endcase
  endfunction

  // Read index: usually the tracked consumer, sometimes one past the writer
  // (ring full at any size), sometimes anywhere.
  function automatic logic [15:0] pick_read();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1, 2:    return wr_pos + 16'd1;
      default: return consumer_rd;
    endcase
  endfunction

  function automatic logic alive_draw();
    return $urandom_range(0, 11) != 0;
  endfunction

  // Register write; only called with the block drained.
  task automatic write_reg(input reg_index_t idx, input logic [16:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RING_SIZE_LOG2) ring_log2_cfg = val[4:0];
    else max_len_cfg = val;
    @(posedge clk);
  endtask

  // One input transaction. Valid is only dropped when a gap is drawn, so
  // back-to-back transactions keep it high with a single update per step.
  task automatic offer_op(input rprc_in_t op);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
    awaited_reports.push_back(apply_ring_op(op));
  endtask

  // Stop offering and wait until every predicted result has come back.
  // Two-stage pipe; the trailing wait covers anything still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_report(input rprc_out_t got);
    rprc_out_t want;
    if (awaited_reports.size() == 0) begin
      $error("result transaction with nothing pending");
      mismatches++;
      return;
    end
    want = awaited_reports.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.slot_number !== want.slot_number) begin
      $error("slot_number: expected %0d, got %0d", want.slot_number, got.slot_number);
      mismatches++;
    end
    if (got.prefix_write !== want.prefix_write) begin
      $error("prefix_write: expected %0d, got %0d", want.prefix_write, got.prefix_write);
      mismatches++;
    end
    if (got.prefix_value !== want.prefix_value) begin
      $error("prefix_value: expected %0d, got %0d", want.prefix_value, got.prefix_value);
      mismatches++;
    end
    if (got.published_write_index !== want.published_write_index) begin
      $error("published_write_index: expected %0d, got %0d",
             want.published_write_index, got.published_write_index);
      mismatches++;
    end
    if (got.free_slots !== want.free_slots) begin
      $error("free_slots: expected %0d, got %0d", want.free_slots, got.free_slots);
      mismatches++;
    end
    if (got.messages_total !== want.messages_total) begin
      $error("messages_total: expected %0d, got %0d",
             want.messages_total, got.messages_total);
      mismatches++;
    end
    if (got.bytes_total !== want.bytes_total) begin
      $error("bytes_total: expected %0d, got %0d", want.bytes_total, got.bytes_total);
      mismatches++;
    end
    if (got.failed_total !== want.failed_total) begin
      $error("failed_total: expected %0d, got %0d", want.failed_total, got.failed_total);
      mismatches++;
    end
  endtask

  // Result side: random stall before each result transaction, or the long
  // one-shot hold-off when a test asks for it. Values are sampled just after
  // the edge, i.e. the pre-edge state the handshake was decided on.
  initial begin : result_monitor
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 6);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_report(out_data);
    end
  end

  // Well-formed reserve/commit and push sequences with random content, plus
  // rollbacks, double reserves and fully random transactions as noise.
  task automatic run_traffic(input int n);
    int       sent;
    rprc_in_t op;
    sent = 0;
    while (sent < n) begin
      // Consumer catches up now and then; small rings fill in between.
      if ($urandom_range(0, 2) == 0) consumer_rd = wr_pos;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          offer_op(mk(ACT_PUSH, pick_len(), pick_read(), alive_draw()));
          sent += 1;
        end
        4, 5, 6: begin
          offer_op(mk(ACT_RESERVE, pick_len(), pick_read(), alive_draw()));
          offer_op(mk(ACT_COMMIT, pick_len(), pick_read(), alive_draw()));
          sent += 2;
        end
        7: begin
          offer_op(mk(ACT_RESERVE, pick_len(), pick_read(), alive_draw()));
          offer_op(mk(ACT_ROLLBACK, pick_len(), pick_read(), alive_draw()));
          sent += 2;
        end
        8: begin
          offer_op(mk(ACT_RESERVE, pick_len(), pick_read(), alive_draw()));
          offer_op(mk(ACT_RESERVE, pick_len(), pick_read(), alive_draw()));
          offer_op(mk(ACT_COMMIT, pick_len(), pick_read(), alive_draw()));
          sent += 3;
        end
        default: begin
          op.action              = action_t'($urandom_range(0, 3));
          op.message_length      = 20'($urandom);
          op.consumer_read_index = 16'($urandom);
          op.reader_attached     = 1'($urandom_range(0, 1));
          offer_op(op);
          sent += 1;
        end
      endcase
    end
  endtask

  // Reset settings (L = 10, max 4096): every status and counter rule once.
  task automatic test_directed_cases();
    offer_op(mk(ACT_RESERVE, 20'd0, 16'd0, 1'b1));            // zero length
    offer_op(mk(ACT_RESERVE, 20'd4097, 16'd0, 1'b1));         // just over max
    offer_op(mk(ACT_RESERVE, 20'hFFFFF, 16'hFFFF, 1'b1));     // field maximum
    offer_op(mk(ACT_COMMIT, 20'd10, 16'd0, 1'b1));            // nothing held
    offer_op(mk(ACT_COMMIT, 20'd0, 16'd0, 1'b0));             // size before nores
    offer_op(mk(ACT_ROLLBACK, 20'd0, 16'd0, 1'b0));           // rollback when idle
    offer_op(mk(ACT_RESERVE, 20'd1, 16'd0, 1'b0));            // consumer gone
    offer_op(mk(ACT_RESERVE, 20'd1, wr_pos + 16'd1, 1'b1));   // full, not a failure
    offer_op(mk(ACT_RESERVE, 20'd4096, 16'd0, 1'b1));         // takes slot 0
    offer_op(mk(ACT_RESERVE, 20'd5, 16'd0, 1'b1));            // busy
    offer_op(mk(ACT_PUSH, 20'd8, 16'd0, 1'b1));               // push while held
    offer_op(mk(ACT_COMMIT, 20'd0, 16'd0, 1'b1));             // bad size keeps hold
    offer_op(mk(ACT_COMMIT, 20'd4096, 16'hFFFF, 1'b0));       // publishes anyway
    offer_op(mk(ACT_PUSH, 20'd0, 16'd0, 1'b0));               // size, not counted
    offer_op(mk(ACT_PUSH, 20'd5, 16'd0, 1'b0));               // closed, counted
    offer_op(mk(ACT_PUSH, 20'd7, wr_pos + 16'd1, 1'b1));      // full, counted
    offer_op(mk(ACT_PUSH, 20'd4096, 16'hFFFF, 1'b1));         // reader wrapped
    offer_op(mk(ACT_RESERVE, 20'd3, 16'd0, 1'b1));
    offer_op(mk(ACT_ROLLBACK, 20'hFFFFF, 16'hFFFF, 1'b1));    // drops the hold
    offer_op(mk(ACT_COMMIT, 20'd3, 16'd0, 1'b1));             // nothing held now
    offer_op(mk(ACT_PUSH, 20'd4097, 16'd0, 1'b1));
    offer_op(mk(ACT_PUSH, 20'd1, 16'd1, 1'b1));
    settle();
  endtask

  // Each setting pair in turn, extremes and clamped sizes included.
  task automatic test_config_sweep();
    int i;
    for (i = 0; i < 8; i++) begin
      write_reg(REG_RING_SIZE_LOG2, 17'(SWEEP_RING[i]));
      write_reg(REG_MAX_MESSAGE_BYTES, 17'(SWEEP_MAX[i]));
      tx_steady = (i % 3 == 0);
      rx_steady = (i % 4 == 1);
      run_traffic(25);
      settle();
    end
  endtask

  // Bulk traffic: a small ring with idling, then a stretch with none,
  // then a large ring with only receiver stalls.
  task automatic test_random_traffic();
    write_reg(REG_RING_SIZE_LOG2, 17'd3);
    write_reg(REG_MAX_MESSAGE_BYTES, 17'd64);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    run_traffic(180);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_traffic(100);
    settle();
    write_reg(REG_RING_SIZE_LOG2, 17'd12);
    write_reg(REG_MAX_MESSAGE_BYTES, 17'd65536);
    rx_steady = 1'b0;
    run_traffic(80);
    tx_steady = 1'b0;
    settle();
  endtask

  // Receiver holds off for a long stretch while pushes keep coming, so the
  // pipe fills and in_ready has to drop.
  task automatic test_backpressure();
    int i;
    hold_req  = 150;
    tx_steady = 1'b1;
    for (i = 0; i < 40; i++) begin
      if (i % 8 == 0) consumer_rd = wr_pos;
      offer_op(mk(ACT_PUSH, pick_len(), pick_read(), alive_draw()));
    end
    tx_steady = 1'b0;
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_config_sweep();
    test_random_traffic();
    test_backpressure();
    repeat (8) @(posedge clk);
    mismatches += awaited_reports.size();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
